### rtl/fpcm_pkg.sv
// shared types, format codes and helpers for the float to pcm sample packer
package fpcm_pkg;

  typedef enum logic [1:0] {
    FMT_PCM16 = 2'd0,
    FMT_PCM24 = 2'd1,
    FMT_PCM32 = 2'd2,
    FMT_FLOAT = 2'd3
  } fmt_e;

  localparam int MidDepth = 2;
  localparam int OutDepth = 8;

  // classified request handed from the front to the back
  typedef struct packed {
    logic        neg;
    logic        zero;
    logic [7:0]  expo;
    logic [23:0] man;
    fmt_e        fmt;
    logic [31:0] raw;
    logic [31:0] data_bytes;
    logic [31:0] riff;
  } cls_t;

  typedef struct packed {
    logic [31:0] packed_word;
    logic [2:0]  byte_count;
    logic [31:0] data_bytes;
    logic [31:0] riff;
  } res_t;

  function automatic logic [5:0] scale_shift(fmt_e f);
    logic [5:0] n;
    case (f)
      FMT_PCM16: n = 6'd15;
      FMT_PCM24: n = 6'd23;
      FMT_PCM32: n = 6'd31;
      default:   n = 6'd0;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] fmt_bytes(fmt_e f);
    logic [2:0] b;
    case (f)
      FMT_PCM16: b = 3'd2;
      FMT_PCM24: b = 3'd3;
      default:   b = 3'd4;
    endcase
    return b;
  endfunction

endpackage

### rtl/fpcm_queue.sv
// small register queue with count
module fpcm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             data_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             data_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [IdxW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == IdxW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == IdxW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### rtl/fpcm_front.sv
// front part: format register, sample classification and running byte total
module fpcm_front import fpcm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        accept_i,
  input  logic [31:0] sample_bits_i,
  output cls_t        cls_o
);

  fmt_e        fmt_q;
  logic [31:0] total_q, total_d;
  logic [2:0]  nbytes;
  logic [7:0]  ex;
  logic [22:0] fr;
  logic        is_nan, over;

  assign ex     = sample_bits_i[30:23];
  assign fr     = sample_bits_i[22:0];
  assign is_nan = (ex == 8'hFF) && (fr != '0);
  // magnitude above one, infinities included
  assign over   = (sample_bits_i[30:0] > 31'h3F80_0000);
  assign nbytes = fmt_bytes(fmt_q);
  assign total_d = total_q + 32'(nbytes);

  always_comb begin
    cls_o.neg  = sample_bits_i[31];
    // nan, zero and subnormals all give zero
    cls_o.zero = is_nan || (ex == '0);
    cls_o.expo = over ? 8'd127 : ex;
    cls_o.man  = over ? 24'h80_0000 : {1'b1, fr};
    cls_o.fmt  = fmt_q;
    cls_o.raw  = sample_bits_i;
    cls_o.data_bytes = total_d;
    cls_o.riff = total_q + (32'(nbytes) + 32'd36);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= FMT_PCM16;
      total_q <= '0;
    end else begin
      if (cfg_we_i) begin
        fmt_q <= fmt_e'(cfg_wdata_i);
      end
      if (accept_i) begin
        total_q <= total_d;
      end
    end
  end

endmodule

### rtl/fpcm_back.sv
// back part: three stage scale, round and truncate datapath
module fpcm_back import fpcm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       issue_i,
  input  cls_t       cls_i,
  output logic       res_valid_o,
  output res_t       res_o,
  output logic [1:0] busy_o
);

  // stage 1: exact product magnitude
  logic        v1_q, v2_q, v3_q;
  cls_t        c1_q, c2_q;
  logic        rnd1_q;
  logic [54:0] p1_q, p1_d;
  logic [5:0]  n0;
  logic [54:0] mn;
  logic        rnd0;

  assign n0   = scale_shift(cls_i.fmt);
  assign mn   = 55'(cls_i.man) << n0;
  // only the positive int16/int24 scales are not powers of two
  assign rnd0 = !cls_i.neg && (cls_i.fmt == FMT_PCM16 || cls_i.fmt == FMT_PCM24);

  always_comb begin
    if (cls_i.zero) begin
      p1_d = '0;
    end else if (rnd0) begin
      p1_d = mn - 55'(cls_i.man);
    end else begin
      p1_d = mn;
    end
  end

  // stage 2: round product to 24 significant bits
  logic [55:0] rp2_q, rp2_d, lowmask, half, rem, pw;
  logic [7:0]  sh2_q;
  logic [5:0]  n1, lsb;
  logic        up;

  assign n1 = scale_shift(c1_q.fmt);

  always_comb begin
    lsb     = (p1_q >= (55'(1) << (n1 + 6'd23))) ? n1 : n1 - 6'd1;
    pw      = 56'(1) << lsb;
    lowmask = pw - 56'd1;
    half    = pw >> 1;
    rem     = {1'b0, p1_q} & lowmask;
    up      = (rem > half) || ((rem == half) && (({1'b0, p1_q} & pw) != '0));
    if (rnd1_q) begin
      rp2_d = ({1'b0, p1_q} & ~lowmask) + (up ? pw : 56'd0);
    end else begin
      rp2_d = {1'b0, p1_q};
    end
  end

  // stage 3: truncate toward zero, sign, saturate, pack
  logic [55:0] mag;
  logic [31:0] word;
  res_t        res_q, res_d;

  always_comb begin
    mag = (sh2_q >= 8'd56) ? 56'd0 : (rp2_q >> sh2_q);
    if (c2_q.neg) begin
      word = -mag[31:0];
    end else if (mag >= 56'h8000_0000) begin
      word = 32'h7FFF_FFFF;
    end else begin
      word = mag[31:0];
    end
    case (c2_q.fmt)
      FMT_PCM16: word = word & 32'h0000_FFFF;
      FMT_PCM24: word = word & 32'h00FF_FFFF;
      FMT_PCM32: word = word;
      default:   word = c2_q.raw;
    endcase
    res_d.packed_word = word;
    res_d.byte_count  = fmt_bytes(c2_q.fmt);
    res_d.data_bytes  = c2_q.data_bytes;
    res_d.riff        = c2_q.riff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= issue_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q   <= cls_i;
    rnd1_q <= rnd0;
    p1_q   <= p1_d;
    c2_q   <= c1_q;
    rp2_q  <= rp2_d;
    sh2_q  <= 8'd150 - c1_q.expo;
    res_q  <= res_d;
  end

  assign res_valid_o = v3_q;
  assign res_o       = res_q;
  assign busy_o      = 2'(v1_q) + 2'(v2_q) + 2'(v3_q);

endmodule

### rtl/float_to_pcm_sample_packer.sv
// a request accepted passes through the mid queue, back stages and result queue to the ports
// throughput: one sample per cycle unless issue is held; single pass, 3 stage back datapath
// the back issues only while the result queue has room for all requests in flight
// reset: asynchronous active low; clears queues, byte total and format (int16)
// top level of the float to pcm sample packer
module float_to_pcm_sample_packer import fpcm_pkg::*; #(
  parameter int MID_DEPTH = MidDepth,
  parameter int OUT_DEPTH = OutDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [31:0] sample_bits_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] packed_word_o,
  output logic [2:0]  byte_count_o,
  output logic [31:0] data_bytes_o,
  output logic [31:0] riff_size_o
);

  localparam int MidCntW = $clog2(MID_DEPTH+1);
  localparam int OutCntW = $clog2(OUT_DEPTH+1);
  localparam int OccW    = $clog2(OUT_DEPTH+4);

  logic               accept, mid_empty, issue, res_valid;
  logic [1:0]         busy;
  logic [MidCntW-1:0] mid_cnt;
  logic [OutCntW-1:0] out_cnt;
  logic [OccW-1:0]    occ;
  logic               out_full;
  cls_t               cls_in, cls_mid;
  res_t               res_in, res_out;

  assign accept = push && !full;

  fpcm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .sample_bits_i (sample_bits_i),
    .cls_o         (cls_in)
  );

  fpcm_queue #(.WIDTH($bits(cls_t)), .DEPTH(MID_DEPTH)) u_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (cls_in),
    .full_o  (full),
    .pop_i   (issue),
    .data_o  (cls_mid),
    .empty_o (mid_empty),
    .count_o (mid_cnt)
  );

  // credit check: queued results plus requests in flight must fit
  assign occ   = OccW'(out_cnt) + OccW'(busy);
  assign issue = !mid_empty && (occ < OccW'(OUT_DEPTH)) && (mid_cnt != '0);

  fpcm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .cls_i       (cls_mid),
    .res_valid_o (res_valid),
    .res_o       (res_in),
    .busy_o      (busy)
  );

  fpcm_queue #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res_in),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty),
    .count_o (out_cnt)
  );

  assign packed_word_o = res_out.packed_word;
  assign byte_count_o  = out_full ? res_out.byte_count : res_out.byte_count;
  assign data_bytes_o  = res_out.data_bytes;
  assign riff_size_o   = res_out.riff;

endmodule

### rtl/fpcm_checker.sv
// port level checks for the float to pcm sample packer, bound to the top level
module fpcm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [1:0]  cfg_wdata_i,
  input logic        push,
  input logic        full,
  input logic [31:0] sample_bits_i,
  input logic        empty,
  input logic        pop,
  input logic [31:0] packed_word_o,
  input logic [2:0]  byte_count_o,
  input logic [31:0] data_bytes_o,
  input logic [31:0] riff_size_o
);

  a_riff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> riff_size_o == data_bytes_o + 32'd36)
    else $error("riff size does not track data bytes");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (byte_count_o == 3'd2 || byte_count_o == 3'd3 || byte_count_o == 3'd4))
    else $error("bad byte count");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && byte_count_o != 3'd4) |->
      (packed_word_o[31:24] == 8'h00 &&
       (byte_count_o == 3'd3 || packed_word_o[23:16] == 8'h00)))
    else $error("unused bytes not zero");

  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty) ##1 !empty |->
      data_bytes_o == $past(data_bytes_o) + 32'(byte_count_o))
    else $error("byte total skipped or repeated");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(packed_word_o) && $stable(data_bytes_o)))
    else $error("stalled result changed");

endmodule

bind float_to_pcm_sample_packer fpcm_checker u_fpcm_checker (.*);

### test/tb_float_to_pcm_sample_packer.sv
// self-checking testbench for the float to pcm sample packer
`timescale 1ns / 100ps

module tb_float_to_pcm_sample_packer;
  import fpcm_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic [31:0] total;
    logic [31:0] riff;
  } pcm_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_wdata_i = FMT_PCM16;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] sample_bits_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] packed_word_o;
  logic [2:0]  byte_count_o;
  logic [31:0] data_bytes_o;
  logic [31:0] riff_size_o;

  pcm_result_t pending_results[$];
  fmt_e        model_fmt = FMT_PCM16;
  logic [31:0] model_total = '0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          errors = 0;
  int          samples_sent = 0;
  int          results_seen = 0;

  float_to_pcm_sample_packer uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .push, .full, .sample_bits_i,
    .empty, .pop, .packed_word_o, .byte_count_o, .data_bytes_o, .riff_size_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("float_to_pcm_sample_packer test failed");
    $finish;
  end

  // clamp, scale, round to single precision, truncate toward zero
  function automatic logic [31:0] pcm_convert(logic [31:0] b, int n);
    logic [7:0]  ex;
    logic [23:0] m;
    logic [63:0] k, p, rem, half, mag;
    int          e, msb, sh;
    bit          neg;
    ex = b[30:23];
    if (ex == 8'hff && b[22:0] != 0) return 32'd0;
    if (ex >= 8'd127) begin
      m = 24'h800000;
      e = -23;
    end else if (ex == 0) begin
      m = {1'b0, b[22:0]};
      e = -149;
    end else begin
      m = {1'b1, b[22:0]};
      e = int'(ex) - 150;
    end
    neg = b[31] && (m != 0);
    if (neg || n == 31) k = 64'd1 << n;
    else k = (64'd1 << n) - 1;
    p = m * k;
    if (p == 0) return 32'd0;
    msb = 0;
    for (int i = 0; i < 64; i++) if (p[i]) msb = i;
    if (msb > 23) begin
      sh = msb - 23;
      rem = p & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      p = p >> sh;
      if (rem > half || (rem == half && p[0])) p = p + 1;
      e = e + sh;
    end
    if (e >= 0) mag = p << e;
    else if (-e >= 64) mag = 0;
    else mag = p >> (-e);
    if (!neg) begin
      if (mag >= 64'h8000_0000) return 32'h7fff_ffff;
      return mag[31:0];
    end
    return -mag[31:0];
  endfunction

  function automatic pcm_result_t pack_sample(logic [31:0] b);
    pcm_result_t r;
    case (model_fmt)
      FMT_PCM16: begin
        r.word = pcm_convert(b, 15) & 32'h0000_ffff;
        r.nbytes = 3'd2;
      end
      FMT_PCM24: begin
        r.word = pcm_convert(b, 23) & 32'h00ff_ffff;
        r.nbytes = 3'd3;
      end
      FMT_PCM32: begin
        r.word = pcm_convert(b, 31);
        r.nbytes = 3'd4;
      end
      default: begin
        r.word = b;
        r.nbytes = 3'd4;
      end
    endcase
    model_total = model_total + r.nbytes;
    r.total = model_total;
    r.riff = model_total + 32'd36;
    return r;
  endfunction

  task automatic send_sample(logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    sample_bits_i <= b;
    do @(posedge clk_i); while (full);
    pending_results.push_back(pack_sample(b));
    samples_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_format(fmt_e f);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= f;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_fmt = f;
  endtask

  // biased toward magnitudes below one, with specials and raw noise
  function automatic logic [31:0] random_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) return $urandom;
    if (pick < 80) return {1'($urandom), 8'($urandom_range(126, 100)), 23'($urandom)};
    case ($urandom_range(7))
      0: return 32'h3f80_0000;
      1: return 32'hbf80_0000;
      2: return {1'($urandom), 8'hff, 23'($urandom)};
      3: return {1'($urandom), 8'h00, 23'($urandom)};
      4: return {1'($urandom), 8'h7e, 23'h7fffff};
      5: return {1'($urandom), 31'h0};
      6: return {1'($urandom), 8'($urandom_range(200, 127)), 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(99, 1)), 23'($urandom)};
    endcase
  endfunction

  always @(posedge clk_i) begin
    pcm_result_t want;
    if (pop && !empty) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected request out, word %h", $time, packed_word_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (packed_word_o !== want.word) begin
          $display("%0t: packed_word expected %h actual %h", $time, want.word,
                   packed_word_o);
          errors++;
        end
        if (byte_count_o !== want.nbytes) begin
          $display("%0t: byte_count expected %0d actual %0d", $time, want.nbytes,
                   byte_count_o);
          errors++;
        end
        if (data_bytes_o !== want.total) begin
          $display("%0t: data_bytes expected %h actual %h", $time, want.total,
                   data_bytes_o);
          errors++;
        end
        if (riff_size_o !== want.riff) begin
          $display("%0t: riff_size expected %h actual %h", $time, want.riff,
                   riff_size_o);
          errors++;
        end
      end
    end
    // long hold-off so the block fills and stalls its input
    if (hold_req && hold_left == 0) hold_left = 300;
    if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) hold_req = 1'b0;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_directed();
    logic [31:0] edge_vals[12] = '{32'h0000_0000, 32'h8000_0000, 32'h3f80_0000,
                                   32'hbf80_0000, 32'h7f80_0000, 32'hff80_0000,
                                   32'h7fc0_0001, 32'h0000_0001, 32'h3f7f_ffff,
                                   32'hbf7f_ffff, 32'h4000_0000, 32'hffff_ffff};
    write_format(FMT_PCM32);
    foreach (edge_vals[i]) send_sample(edge_vals[i]);
    write_format(FMT_PCM16);
    send_sample(32'h3f80_0000);
    send_sample(32'hbf80_0000);
    send_sample(32'h3eff_ffff);
    write_format(FMT_PCM24);
    send_sample(32'h3f80_0000);
    send_sample(32'hbf80_0000);
    send_sample(32'h3f7f_ffff);
    write_format(FMT_FLOAT);
    send_sample(32'h7fc0_0001);
    send_sample(32'hffff_ffff);
  endtask

  task automatic test_random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 160 == 0) write_format(fmt_e'($urandom_range(3)));
      send_sample(random_sample());
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_sample(random_sample());
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle_pct = 33;
    recv_idle_pct = 76;
    test_random_phase(620);
    test_backpressure();
    send_idle_pct = 76;
    recv_idle_pct = 33;
    test_random_phase(620);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_phase(620);
    wait_drained();
    $display("%0d samples sent, %0d results checked over all four formats,",
             samples_sent, results_seen);
    $display("with edge values, specials, random idling and a full-queue stall");
    if (errors == 0) begin
      $display("float_to_pcm_sample_packer test passed");
    end else begin
      $display("float_to_pcm_sample_packer test failed");
    end
    $finish;
  end

endmodule
